/* src/pulse_rate_estimator_defines.svh */
// assertion macros shared by the pulse rate estimator
`ifndef PULSE_RATE_ESTIMATOR_DEFINES_SVH
`define PULSE_RATE_ESTIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pulse rate estimator check failed");
// next-cycle implication
`define PRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pulse rate estimator check failed");
`else
`define PRE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PRE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/pre_pkg.sv */
package pre_pkg;

	// input item
	typedef struct packed {
		logic [15:0] reading;
		logic [31:0] timestamp_us;
	} pre_in_t;

	// result item
	typedef struct packed {
		logic [15:0] bpm_q8;
		logic        beat_accepted;
	} pre_out_t;

	// live register values
	typedef struct packed {
		logic [15:0] lo_thresh;
		logic [15:0] hi_thresh;
		logic [23:0] min_interval_us;
		logic [23:0] max_interval_us;
	} pre_cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        accepted;
		logic [23:0] interval;
	} pre_rec_t;

	// register indexes
	localparam logic [1:0] REG_LO_THRESH    = 2'd0;
	localparam logic [1:0] REG_HI_THRESH    = 2'd1;
	localparam logic [1:0] REG_MIN_INTERVAL = 2'd2;
	localparam logic [1:0] REG_MAX_INTERVAL = 2'd3;

	// register reset values
	localparam logic [15:0] LO_THRESH_RST    = 16'd24576;
	localparam logic [15:0] HI_THRESH_RST    = 16'd40960;
	localparam logic [23:0] MIN_INTERVAL_RST = 24'd300000;
	localparam logic [23:0] MAX_INTERVAL_RST = 24'd1500000;

	// 60e6 us per minute times 256 for q8
	localparam logic [63:0] BPM_NUM_UNIT = 64'd15360000000;
	localparam logic [15:0] BPM_SAT      = 16'hFFFF;

	// back end sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} pre_state_t;

endpackage

/* src/pulse_rate_estimator.sv */
// Pulse rate estimator: a hysteresis beat detector on 16-bit readings with microsecond
// timestamps, averaging the last RING_DEPTH in-range beat intervals into a Q8.8 BPM
// figure (0 until the interval ring has filled, saturating at 65535). Every input item
// gives exactly one result item carrying the held BPM and a beat flag. Items are
// classified on entry and wait in a two-item queue for the back end. In the back end
// an item without an accepted beat goes straight to the done state, an accepted beat
// that leaves the ring short of full first passes the read state, and one that leaves
// the ring full then also passes the check state and the 16-step restoring divider
// that forms the quotient one bit a cycle (skipped when the figure saturates); the
// done state loads the output register once it is free. Registers are written on
// cfg_we with cfg_index 0..3 (low threshold, high threshold, minimum interval,
// maximum interval) and must only be changed while no item is in flight.
module pulse_rate_estimator
	import pre_pkg::*;
#(
	parameter int RING_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pre_in_t     in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output pre_out_t    out_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	pre_cfg_t cfg_q;
	logic     q_full;
	logic     push;
	pre_rec_t push_rec;
	logic     pop;
	logic     q_valid;
	pre_rec_t q_rec;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lo_thresh       <= LO_THRESH_RST;
			cfg_q.hi_thresh       <= HI_THRESH_RST;
			cfg_q.min_interval_us <= MIN_INTERVAL_RST;
			cfg_q.max_interval_us <= MAX_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LO_THRESH:    cfg_q.lo_thresh       <= cfg_data[15:0];
				REG_HI_THRESH:    cfg_q.hi_thresh       <= cfg_data[15:0];
				REG_MIN_INTERVAL: cfg_q.min_interval_us <= cfg_data;
				REG_MAX_INTERVAL: cfg_q.max_interval_us <= cfg_data;
				default: ;
			endcase
		end
	end

	pre_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item (in_item),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.push    (push),
		.rec     (push_rec)
	);

	pre_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.pop_valid(q_valid),
		.pop_rec  (q_rec)
	);

	pre_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_rec    (q_rec),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

/* src/pre_ram.sv */
module pre_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/pre_front.sv */
module pre_front
	import pre_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pre_in_t  in_item,
	input  pre_cfg_t cfg,
	input  logic     q_full,
	output logic     push,
	output pre_rec_t rec
);

	logic        rising_q;
	logic [31:0] last_edge_q;
	logic        set_edge;
	logic        clr_edge;
	logic [31:0] interval;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// hysteresis: only the test matching the current flag is made
	assign set_edge = !rising_q && (in_item.reading > cfg.hi_thresh);
	assign clr_edge = rising_q && (in_item.reading < cfg.lo_thresh);
	assign interval = in_item.timestamp_us - last_edge_q;

	// classify the item for the back end
	always_comb begin
		rec.interval = interval[23:0];
		rec.accepted = set_edge
			&& (interval > {8'h00, cfg.min_interval_us})
			&& (interval < {8'h00, cfg.max_interval_us});
	end

	// flag and edge time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rising_q    <= 1'b0;
			last_edge_q <= '0;
		end else if (push) begin
			if (set_edge) begin
				rising_q    <= 1'b1;
				last_edge_q <= in_item.timestamp_us;
			end else if (clr_edge) begin
				rising_q <= 1'b0;
			end
		end
	end

endmodule

/* src/pre_queue.sv */
module pre_queue
	import pre_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pre_rec_t push_rec,
	output logic     full,
	input  logic     pop,
	output logic     pop_valid,
	output pre_rec_t pop_rec
);

	pre_rec_t   buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_rec   = buf_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* src/pre_back.sv */
`include "pulse_rate_estimator_defines.svh"
module pre_back
	import pre_pkg::*;
#(
	parameter int RING_DEPTH = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  pre_rec_t q_rec,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_ready,
	output pre_out_t out_item
);

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W = 24 + $clog2(RING_DEPTH);
	localparam logic [SUM_W+15:0] NUM_C = (SUM_W + 16)'(BPM_NUM_UNIT * 64'(RING_DEPTH));
	localparam logic [SUM_W-1:0]  NUM_HI = SUM_W'(NUM_C >> 16);
	localparam logic [15:0]       NUM_LO = NUM_C[15:0];
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(RING_DEPTH);

	pre_state_t       state_q;
	pre_state_t       state_d;
	logic [23:0]      interval_q;
	logic [PTR_W-1:0] pos_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [15:0]      held_q;
	logic             beat_q;
	logic [SUM_W-1:0] rem_q;
	logic [15:0]      quo_q;
	logic [3:0]       bit_q;
	logic             out_valid_q;
	pre_out_t         out_q;

	logic             ram_re;
	logic             ram_we;
	logic [23:0]      ram_rdata;
	logic             out_load;
	logic [SUM_W-1:0] old_entry;
	logic [SUM_W-1:0] sum_new;
	logic             will_fill;
	logic [SUM_W:0]   trial;
	logic             trial_ge;
	logic             sat;

	pre_ram #(
		.WIDTH(24),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata(interval_q),
		.re   (ram_re),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	// ring update: entries beyond the fill count read as zero
	assign old_entry = (count_q == CNT_FULL) ? SUM_W'(ram_rdata) : '0;
	assign sum_new   = sum_q - old_entry + SUM_W'(interval_q);
	assign will_fill = (count_q >= CNT_FULL - CNT_W'(1));

	// restoring division step and saturation test
	assign trial    = {rem_q, NUM_LO[bit_q]};
	assign trial_ge = (trial >= {1'b0, sum_q});
	assign sat      = (NUM_C >= {sum_q, 16'h0000});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = q_rec.accepted ? ST_READ : ST_DONE;
				end
			end
			ST_READ:  state_d = will_fill ? ST_CHECK : ST_DONE;
			ST_CHECK: state_d = sat ? ST_DONE : ST_DIV;
			ST_DIV: begin
				if (bit_q == 4'd0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop      = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop    = q_valid;
				ram_re = q_valid && q_rec.accepted;
			end
			ST_READ: ram_we = 1'b1;
			ST_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring bookkeeping and held figure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
			held_q  <= '0;
			beat_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						beat_q <= q_rec.accepted;
					end
				end
				ST_READ: begin
					sum_q <= sum_new;
					pos_q <= (pos_q == PTR_LAST) ? '0 : pos_q + PTR_W'(1);
					if (count_q != CNT_FULL) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_CHECK: begin
					if (sat) begin
						held_q <= BPM_SAT;
					end
				end
				ST_DIV: begin
					if (bit_q == 4'd0) begin
						held_q <= {quo_q[14:0], trial_ge};
					end
				end
				default: ;
			endcase
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			interval_q <= q_rec.interval;
		end
		if (state_q == ST_CHECK) begin
			rem_q <= NUM_HI;
			quo_q <= '0;
			bit_q <= 4'd15;
		end else if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
			quo_q <= {quo_q[14:0], trial_ge};
			bit_q <= bit_q - 4'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.bpm_q8        <= held_q;
			out_q.beat_accepted <= beat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`PRE_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, (count_q <= CNT_FULL))
	`PRE_ASSERT_NOW(a_held_zero_until_full, clk, arst_n, (count_q != CNT_FULL), (held_q == 16'h0000))
	`PRE_ASSERT_NEXT(a_idle_keeps_held, clk, arst_n, (state_q == ST_IDLE), $stable(held_q))

endmodule
